### hdl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/tptu_pkg.sv
package tptu_pkg;

    // Sizing
    localparam int TLB_ENTRIES = 16;
    localparam int PAGE_COUNT  = 256;
    localparam int PAGE_SIZE   = 256;

    localparam int VA_W     = 16;
    localparam int PA_W     = 16;
    localparam int OFFSET_W = $clog2(PAGE_SIZE);
    localparam int PAGE_W   = $clog2(PAGE_COUNT);
    localparam int FRAME_W  = PAGE_W;
    localparam int SLOT_W   = $clog2(TLB_ENTRIES);
    localparam int FILL_W   = $clog2(TLB_ENTRIES + 1);
    localparam int NEXT_W   = $clog2(PAGE_COUNT + 1);
    localparam int MAP_W    = FRAME_W + 1;

    typedef logic [PAGE_W-1:0]   page_t;
    typedef logic [FRAME_W-1:0]  frame_t;
    typedef logic [OFFSET_W-1:0] offset_t;

    // TLB lookup answer
    typedef struct packed {
        logic   hit;
        frame_t frame;
    } tlb_lookup_t;

    // TLB insert request
    typedef struct packed {
        logic   en;
        page_t  page;
        frame_t frame;
    } tlb_insert_t;

endpackage

### hdl/tptu_ram.sv
module tptu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/tptu_tlb.sv
module tptu_tlb
    import tptu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  page_t       lookup_page,
    output tlb_lookup_t lookup,
    input  tlb_insert_t insert
);

    page_t              tag_reg   [TLB_ENTRIES];
    frame_t             frame_reg [TLB_ENTRIES];
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [SLOT_W-1:0]  victim_reg, victim_next;
    logic [SLOT_W-1:0]  slot;
    logic               full;

    // Associative match over the filled slots; lowest slot wins
    always_comb
    begin
        lookup.hit   = 1'b0;
        lookup.frame = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if ((FILL_W'(i) < fill_reg) && (tag_reg[i] == lookup_page))
            begin
                lookup.hit   = 1'b1;
                lookup.frame = frame_reg[i];
            end
        end
    end

    // Slot choice: free slots first, then FIFO eviction
    always_comb
    begin
        full        = (fill_reg == FILL_W'(TLB_ENTRIES));
        fill_next   = fill_reg;
        victim_next = victim_reg;
        slot        = fill_reg[SLOT_W-1:0];
        if (full)
        begin
            slot = victim_reg;
        end
        if (insert.en)
        begin
            if (!full)
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
            else if (victim_reg == SLOT_W'(TLB_ENTRIES - 1))
            begin
                victim_next = '0;
            end
            else
            begin
                victim_next = victim_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            victim_reg <= '0;
        end
        else
        begin
            fill_reg   <= fill_next;
            victim_reg <= victim_next;
        end
    end

    // Slot contents, written on insert only
    always_ff @(posedge clk)
    begin
        if (insert.en)
        begin
            tag_reg[slot]   <= insert.page;
            frame_reg[slot] <= insert.frame;
        end
    end

endmodule

### hdl/tlb_page_translation_unit.sv
// Channel   Ports                                      Transfer
// -------   ----------------------------------------   ------------------------
// input     start, busy, virtual_address               start high, busy low
// result    done, physical_address, tlb_hit, page_fault one cycle, done high
//
// An address goes through the page map RAM read in the start cycle,
// then TLB match, map update and TLB insert in the lookup cycle. The result
// is shown the cycle after, while the next address may already be taken.
// After reset busy stays high while the page map is cleared,
// one entry a cycle. The receiver cannot stall; results are never held.
`include "assert_macros.svh"

module tlb_page_translation_unit
    import tptu_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [VA_W-1:0] virtual_address,
    output logic            done,
    output logic [PA_W-1:0] physical_address,
    output logic            tlb_hit,
    output logic            page_fault
);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_LOOKUP = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [PAGE_W-1:0] clear_cnt_reg, clear_cnt_next;
    logic [NEXT_W-1:0] next_frame_reg, next_frame_next;
    logic [VA_W-1:0]   addr_reg;
    logic              done_reg, done_next;
    logic [PA_W-1:0]   pa_reg;
    logic              hit_reg;
    logic              fault_reg;

    logic              take;
    page_t             page_in;
    page_t             page_cur;
    offset_t           offset_cur;
    logic              map_we;
    logic [PAGE_W-1:0] map_waddr;
    logic [MAP_W-1:0]  map_wdata;
    logic [MAP_W-1:0]  map_rdata;
    tlb_lookup_t       lookup;
    tlb_insert_t       insert;
    frame_t            frame_sel;
    logic              fault_now;

    assign take       = start && !busy;
    assign page_in    = virtual_address[OFFSET_W +: PAGE_W];
    assign page_cur   = addr_reg[OFFSET_W +: PAGE_W];
    assign offset_cur = addr_reg[OFFSET_W-1:0];

    // Page map: valid bit over frame number
    tptu_ram #(
        .WIDTH(MAP_W),
        .DEPTH(PAGE_COUNT)
    ) u_page_map (
        .clk  (clk),
        .we   (map_we),
        .waddr(map_waddr),
        .wdata(map_wdata),
        .re   (take),
        .raddr(page_in),
        .rdata(map_rdata)
    );

    tptu_tlb u_tlb (
        .clk        (clk),
        .rst_n      (rst_n),
        .lookup_page(page_cur),
        .lookup     (lookup),
        .insert     (insert)
    );

    // Translation in the lookup cycle
    always_comb
    begin
        fault_now = 1'b0;
        frame_sel = lookup.frame;
        if (!lookup.hit)
        begin
            if (map_rdata[MAP_W-1])
            begin
                frame_sel = map_rdata[FRAME_W-1:0];
            end
            else
            begin
                frame_sel = next_frame_reg[FRAME_W-1:0];
                fault_now = 1'b1;
            end
        end
        insert.en    = (state_reg == ST_LOOKUP) && !lookup.hit;
        insert.page  = page_cur;
        insert.frame = frame_sel;
    end

    // Page map write: clearing sweep or fault fill
    always_comb
    begin
        map_we    = 1'b0;
        map_waddr = page_cur;
        map_wdata = {1'b1, next_frame_reg[FRAME_W-1:0]};
        if (state_reg == ST_CLEAR)
        begin
            map_we    = 1'b1;
            map_waddr = clear_cnt_reg;
            map_wdata = '0;
        end
        else if ((state_reg == ST_LOOKUP) && fault_now)
        begin
            map_we = 1'b1;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        clear_cnt_next  = clear_cnt_reg;
        next_frame_next = next_frame_reg;
        done_next       = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clear_cnt_next = clear_cnt_reg + PAGE_W'(1);
                if (clear_cnt_reg == PAGE_W'(PAGE_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (fault_now && (next_frame_reg < NEXT_W'(PAGE_COUNT)))
                begin
                    next_frame_next = next_frame_reg + NEXT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clear_cnt_reg  <= '0;
            next_frame_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_cnt_reg  <= clear_cnt_next;
            next_frame_reg <= next_frame_next;
            done_reg       <= done_next;
        end
    end

    // Address capture and result register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            addr_reg <= virtual_address;
        end
        if (state_reg == ST_LOOKUP)
        begin
            pa_reg    <= PA_W'({frame_sel, offset_cur});
            hit_reg   <= lookup.hit;
            fault_reg <= fault_now;
        end
    end

    assign busy             = (state_reg != ST_IDLE);
    assign done             = done_reg;
    assign physical_address = pa_reg;
    assign tlb_hit          = hit_reg;
    assign page_fault       = fault_reg;

    // Checks
    `ASSERT_NEXT(a_lookup_done, clk, rst_n, state_reg == ST_LOOKUP, done)
    `ASSERT_IMPLIES(a_hit_no_fault, clk, rst_n, done, !(tlb_hit && page_fault))
    `ASSERT_ALWAYS(a_frame_bound, clk, rst_n, next_frame_reg <= NEXT_W'(PAGE_COUNT))
    `ASSERT_IMPLIES(a_no_take_clear, clk, rst_n, state_reg == ST_CLEAR, !take)

endmodule
